[rtl/lzss_ring_decoder_unit_macros.svh]
// ----------------------------------------------------------------------------
// LZSS ring decoder assertion macros
// Shared property wrappers used by the port-level checker.
// ----------------------------------------------------------------------------
`ifndef LZSS_RING_DECODER_UNIT_MACROS_SVH
`define LZSS_RING_DECODER_UNIT_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define LRD_CHK_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, ignored while reset is asserted.
`define LRD_CHK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that is also checked across reset.
`define LRD_CHK_RESET(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/lrd_pkg.sv]
// ----------------------------------------------------------------------------
// LZSS ring decoder package
// Sizes, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lrd_pkg;

    // Ring depth must be a power of two between 256 and 65536.
    localparam int RING_DEPTH     = 4096;
    localparam int START_POSITION = 4078;
    localparam int RING_AW        = $clog2(RING_DEPTH);
    localparam int FILL_W         = RING_AW + 1;

    localparam logic [RING_AW-1:0] START_PTR = RING_AW'(START_POSITION % RING_DEPTH);
    localparam logic [FILL_W-1:0]  FILL_FULL = FILL_W'(RING_DEPTH);

    localparam int                 CNT_W     = 24;
    localparam logic [CNT_W-1:0]   CNT_MAX   = {CNT_W{1'b1}};

    localparam logic [7:0]         SPACE_BYTE = 8'h20;
    localparam logic [15:0]        FLAG_FILL  = 16'hFF00;
    localparam logic [4:0]         MIN_EXTRA  = 5'd2;  // match length 3, minus the first byte

    typedef enum logic [1:0] {
        PH_FLAG  = 2'd0,
        PH_TOKEN = 2'd1,
        PH_HIGH  = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_READ = 2'd1,
        ST_EMIT = 2'd2
    } t_state;

    typedef struct packed {
        logic take;   // input beat accepted this cycle
        logic rd;     // read the ring at the copy pointer
        logic emit;   // load the output register and write the ring
    } t_cmd;

    typedef struct packed {
        logic start_lit;  // the offered beat is a literal to emit
        logic start_ref;  // the offered beat completes a back reference
        logic out_free;   // the output register can take a byte now
        logic more;       // the byte being emitted is not the last of the run
    } t_sts;

endpackage

`default_nettype wire

[rtl/lrd_controller.sv]
// ----------------------------------------------------------------------------
// LZSS ring decoder controller
// Sequences intake, ring reads and byte emission.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lrd_controller (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_in_valid,
    output logic              o_in_stall,
    input  wire lrd_pkg::t_sts i_sts,
    output lrd_pkg::t_cmd     o_cmd
);
    import lrd_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    if (i_sts.start_lit) begin
                        n_state = ST_EMIT;
                    end else if (i_sts.start_ref) begin
                        n_state = ST_READ;
                    end
                end
            end
            ST_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = i_sts.more ? ST_READ : ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/lrd_datapath.sv]
// ----------------------------------------------------------------------------
// LZSS ring decoder datapath
// Token parsing, history ring, counters and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lrd_datapath (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire lrd_pkg::t_cmd            i_cmd,
    output lrd_pkg::t_sts                 o_sts,
    input  wire logic                     i_cfg_we,
    input  wire logic [lrd_pkg::CNT_W-1:0] i_cfg_data,
    input  wire logic [7:0]               i_in_byte,
    input  wire logic                     i_new_stream,
    output logic                          o_out_valid,
    input  wire logic                     i_out_stall,
    output logic [7:0]                    o_out_byte,
    output logic                          o_last_of_run,
    output logic                          o_stream_done
);
    import lrd_pkg::*;

    // Ring store; entries outside the written span read as spaces.
    logic [7:0] mem [RING_DEPTH];

    logic [CNT_W-1:0]   r_out_len;
    t_phase             r_phase,  n_phase;
    logic [15:0]        r_flags,  n_flags;
    logic [CNT_W-1:0]   r_count,  n_count;
    logic [RING_AW-1:0] r_wp,     n_wp;
    logic [FILL_W-1:0]  r_fill,   n_fill;
    logic               r_out_valid, n_out_valid;

    logic [7:0]         r_saved,  n_saved;
    logic [RING_AW-1:0] r_rp,     n_rp;
    logic [4:0]         r_left,   n_left;
    logic               r_is_lit, n_is_lit;
    logic [7:0]         r_lit_byte, n_lit_byte;
    logic [7:0]         r_rdata;
    logic               r_rd_valid;
    logic [7:0]         r_out_byte, n_out_byte;
    logic               r_out_last, n_out_last;
    logic               r_out_done, n_out_done;

    // Intake view of the state, after an optional restart.
    t_phase             e_phase;
    logic [15:0]        e_flags;
    logic [CNT_W-1:0]   e_count;
    logic [RING_AW-1:0] e_wp;
    logic [FILL_W-1:0]  e_fill;
    logic               active;
    logic [15:0]        flags_sh;
    t_phase             phase_after;
    logic [11:0]        ref_pos;
    logic [RING_AW+11:0] ref_pos_ext;

    logic [RING_AW-1:0] rd_offset;
    logic               rd_valid;
    logic [7:0]         emit_byte;
    logic [CNT_W-1:0]   count_inc;
    logic               emit_done;
    logic               start_lit;
    logic               start_ref;

    assign e_phase  = i_new_stream ? PH_FLAG   : r_phase;
    assign e_flags  = i_new_stream ? 16'h0000  : r_flags;
    assign e_count  = i_new_stream ? '0        : r_count;
    assign e_wp     = i_new_stream ? START_PTR : r_wp;
    assign e_fill   = i_new_stream ? '0        : r_fill;
    assign active   = (e_count < r_out_len);

    assign flags_sh    = e_flags >> 1;
    assign phase_after = flags_sh[8] ? PH_TOKEN : PH_FLAG;
    assign ref_pos     = {i_in_byte[7:4], r_saved};
    assign ref_pos_ext = {{RING_AW{1'b0}}, ref_pos};

    // Ring entries are written in order from the start pointer, so the fill
    // count alone tells whether an entry holds stream data yet.
    assign rd_offset = r_rp - START_PTR;
    assign rd_valid  = r_fill[RING_AW] || ({1'b0, rd_offset} < r_fill);

    assign emit_byte = r_is_lit   ? r_lit_byte :
                       r_rd_valid ? r_rdata    : SPACE_BYTE;
    assign count_inc = (r_count == CNT_MAX) ? r_count : r_count + 1'b1;
    assign emit_done = (count_inc >= r_out_len);

    always_comb begin
        start_lit = 1'b0;
        start_ref = 1'b0;
        if (active) begin
            case (e_phase)
                PH_TOKEN: start_lit = e_flags[0];
                PH_HIGH:  start_ref = 1'b1;
                default:  start_lit = 1'b0;
            endcase
        end
    end

    assign o_sts.start_lit = start_lit;
    assign o_sts.start_ref = start_ref;
    assign o_sts.out_free  = !r_out_valid || !i_out_stall;
    assign o_sts.more      = !r_is_lit && (r_left != 5'd0) && !emit_done;

    always_comb begin
        n_phase     = r_phase;
        n_flags     = r_flags;
        n_count     = r_count;
        n_wp        = r_wp;
        n_fill      = r_fill;
        n_saved     = r_saved;
        n_rp        = r_rp;
        n_left      = r_left;
        n_is_lit    = r_is_lit;
        n_lit_byte  = r_lit_byte;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;
        n_out_done  = r_out_done;

        if (i_cmd.take) begin
            n_phase = e_phase;
            n_flags = e_flags;
            n_count = e_count;
            n_wp    = e_wp;
            n_fill  = e_fill;
            if (active) begin
                case (e_phase)
                    PH_TOKEN: begin
                        if (e_flags[0]) begin
                            n_is_lit   = 1'b1;
                            n_lit_byte = i_in_byte;
                            n_flags    = flags_sh;
                            n_phase    = phase_after;
                        end else begin
                            n_saved = i_in_byte;
                            n_phase = PH_HIGH;
                        end
                    end
                    PH_HIGH: begin
                        n_is_lit = 1'b0;
                        n_rp     = ref_pos_ext[RING_AW-1:0];
                        n_left   = {1'b0, i_in_byte[3:0]} + MIN_EXTRA;
                        n_flags  = flags_sh;
                        n_phase  = phase_after;
                    end
                    default: begin
                        n_flags = FLAG_FILL | {8'h00, i_in_byte};
                        n_phase = PH_TOKEN;
                    end
                endcase
            end
        end

        if (i_cmd.emit) begin
            n_wp        = r_wp + 1'b1;
            n_fill      = r_fill[RING_AW] ? r_fill : r_fill + 1'b1;
            n_count     = count_inc;
            n_rp        = r_rp + 1'b1;
            n_left      = (r_left == 5'd0) ? r_left : r_left - 1'b1;
            n_out_valid = 1'b1;
            n_out_byte  = emit_byte;
            n_out_last  = !o_sts.more;
            n_out_done  = emit_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_len   <= '0;
            r_phase     <= PH_FLAG;
            r_flags     <= '0;
            r_count     <= '0;
            r_wp        <= START_PTR;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_out_len <= i_cfg_data;
            end
            r_phase     <= n_phase;
            r_flags     <= n_flags;
            r_count     <= n_count;
            r_wp        <= n_wp;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_saved    <= n_saved;
        r_rp       <= n_rp;
        r_left     <= n_left;
        r_is_lit   <= n_is_lit;
        r_lit_byte <= n_lit_byte;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
        r_out_done <= n_out_done;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            mem[r_wp] <= emit_byte;
        end
        if (i_cmd.rd) begin
            r_rdata    <= mem[r_rp];
            r_rd_valid <= rd_valid;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_last_of_run = r_out_last;
    assign o_stream_done = r_out_done;

endmodule

`default_nettype wire

[rtl/lzss_ring_decoder_unit.sv]
// ----------------------------------------------------------------------------
// LZSS ring decoder unit
// Expands an LZSS stream (4096-byte window, matches of 3 to 18) into bytes.
// ----------------------------------------------------------------------------
// Usage: compressed bytes enter on the input channel (i_in_valid / o_in_stall),
// one byte per beat; i_new_stream on a beat restarts the stream before that
// byte is decoded. Decoded bytes leave on the output channel (o_out_valid /
// i_out_stall), with o_last_of_run marking the final byte caused by one input
// beat and o_stream_done marking the byte that reaches the configured length.
// The length is written through i_cfg_we / i_cfg_data; the user must write it
// only while the unit is idle, and nothing in the unit itself enforces this.
// Sequencing: a flag byte or the low byte of a reference is taken while the
// unit stays idle. A literal beat moves the controller to its emit state,
// which loads the output register. Each byte of a reference passes a
// registered ring read state and then an emit state.
// The input is stalled whenever an emission is in progress.
// Reset empties the history (it reads as spaces), clears the length register
// and the output register. When the receiver stalls, the held byte stays put
// and the ring copy waits at the emit step until the output register frees.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lzss_ring_decoder_unit (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [lrd_pkg::CNT_W-1:0] i_cfg_data,
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire logic [7:0]                i_in_byte,
    input  wire logic                      i_new_stream,
    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output logic [7:0]                     o_out_byte,
    output logic                           o_last_of_run,
    output logic                           o_stream_done
);
    import lrd_pkg::*;

    // Commands from the sequencer and status from the datapath.
    t_cmd cmd;
    t_sts sts;

    lrd_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // The datapath owns the ring, the token state and the output register.
    lrd_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_in_byte     (i_in_byte),
        .i_new_stream  (i_new_stream),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_byte    (o_out_byte),
        .o_last_of_run (o_last_of_run),
        .o_stream_done (o_stream_done)
    );

endmodule

`default_nettype wire

[rtl/lrd_checker.sv]
// ----------------------------------------------------------------------------
// LZSS ring decoder port checker
// Port-level properties of the decoder, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "lzss_ring_decoder_unit_macros.svh"

module lrd_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_in_stall,
    input wire logic       o_out_valid,
    input wire logic       i_out_stall,
    input wire logic [7:0] o_out_byte,
    input wire logic       o_last_of_run,
    input wire logic       o_stream_done
);

    logic       out_held;
    logic       done_beat;
    logic [9:0] out_beat;

    assign out_held  = o_out_valid && i_out_stall;
    assign done_beat = o_out_valid && o_stream_done;
    assign out_beat  = {o_out_byte, o_last_of_run, o_stream_done};

    // A stalled output beat keeps its valid and its payload.
    `LRD_CHK_NEXT(a_out_hold, out_held, o_out_valid && $stable(out_beat), "stalled beat changed")

    // Reaching the stream length always ends the run of the current beat.
    `LRD_CHK_NOW(a_done_is_last, done_beat, o_last_of_run, "done without end of run")

    // Out of reset the unit holds no output and takes input.
    `LRD_CHK_RESET(a_reset_clean, !i_rst_n, !o_out_valid && !o_in_stall, "not clean after reset")

endmodule

bind lzss_ring_decoder_unit lrd_checker u_lrd_checker (.*);

`default_nettype wire
